@@ hw/rtl/battery_level_sampler_top_defines.svh @@
// Assertion macros used by the battery level sampler top level.
`ifndef BATTERY_LEVEL_SAMPLER_TOP_DEFINES_SVH
`define BATTERY_LEVEL_SAMPLER_TOP_DEFINES_SVH

// checked only outside reset
`define BLS_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// checked on every edge, reset included
`define BLS_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);

`endif

@@ hw/rtl/blsmp_pkg.sv @@
// Types and constants of the battery level sampler.
package blsmp_pkg;

   typedef enum logic [1:0] {
      PH_IDLE    = 2'd0,
      PH_PREPARE = 2'd1,
      PH_START   = 2'd2,
      PH_RESULT  = 2'd3
   } phase_type;

   typedef enum logic [1:0] {
      CSR_PERIOD_TICKS = 2'd0,
      CSR_GAIN_Q16     = 2'd1,
      CSR_OFFSET_Q16   = 2'd2
   } csr_index_type;

   localparam logic [15:0]        PERIOD_RESET = 16'd40;
   localparam logic [16:0]        GAIN_RESET   = 17'd12227;
   localparam logic signed [26:0] OFFSET_RESET = -27'sd35873624;

   localparam int unsigned PCT_MAX  = 100;
   localparam int unsigned Q16_HALF = 32768;
   localparam int unsigned Q16_FRAC = 16;

   typedef struct packed {
      logic [15:0]        period_ticks;
      logic [16:0]        gain_q16;
      logic signed [26:0] offset_q16;
   } cfg_type;

   typedef struct packed {
      logic [31:0] now_ticks;
      logic        adc_ready;
      logic [11:0] adc_sample;
   } item_type;

   typedef struct packed {
      logic        measurement_done;
      logic [6:0]  level_percent;
      logic [11:0] average_raw;
      logic        sensor_power;
      logic        convert_start;
   } result_type;

endpackage

@@ hw/rtl/blsmp_csr.sv @@
// Configuration registers: period, gain and offset.
module blsmp_csr
   import blsmp_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [26:0] csr_wdata,
   output cfg_type     cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_PERIOD_TICKS: cfg_in.period_ticks = csr_wdata[15:0];
            CSR_GAIN_Q16:     cfg_in.gain_q16     = csr_wdata[16:0];
            CSR_OFFSET_Q16:   cfg_in.offset_q16   = $signed(csr_wdata);
            default:          cfg_in              = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.period_ticks <= PERIOD_RESET;
         cfg_ff.gain_q16     <= GAIN_RESET;
         cfg_ff.offset_q16   <= OFFSET_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

@@ hw/rtl/blsmp_scale.sv @@
// Average-to-percent conversion: Q16 gain and offset, round half up, clamp 0..100.
module blsmp_scale
   import blsmp_pkg::*;
#(
   parameter int ADC_BITS = 12
) (
   input  logic [ADC_BITS-1:0] average,
   input  logic [16:0]         gain_q16,
   input  logic signed [26:0]  offset_q16,
   output logic [6:0]          percent
);

   localparam int PROD_W = ADC_BITS + 17;
   localparam int V_W    = ((PROD_W > 27) ? PROD_W : 27) + 2;
   localparam int R_W    = V_W - Q16_FRAC;

   logic [V_W-1:0]        prod;
   logic signed [V_W-1:0] value;
   logic [V_W-1:0]        rounded;
   logic [R_W-1:0]        whole;

   assign prod    = V_W'(average) * V_W'(gain_q16);
   assign value   = $signed(prod) + V_W'(offset_q16);
   assign rounded = $unsigned(value) + V_W'(Q16_HALF);
   assign whole   = rounded[V_W-1:Q16_FRAC];

   always_comb begin
      priority if (value[V_W-1]) begin
         percent = 7'd0;
      end else if (whole > R_W'(PCT_MAX)) begin
         percent = 7'(PCT_MAX);
      end else begin
         percent = whole[6:0];
      end
   end

endmodule

@@ hw/rtl/blsmp_core.sv @@
// Measurement sequencer: schedule, power, conversion pulses, sample accumulation.
module blsmp_core
   import blsmp_pkg::*;
#(
   parameter int SAMPLES_LOG2 = 4,
   parameter int ADC_BITS     = 12,
   parameter int TIME_BITS    = 32
) (
   input  logic       clock,
   input  logic       reset,
   input  cfg_type    cfg,
   input  item_type   item,
   input  logic       fire,
   output result_type result
);

   localparam int SUM_W   = ADC_BITS + SAMPLES_LOG2;
   localparam int TAKEN_W = SAMPLES_LOG2 + 1;

   phase_type              phase_ff, phase_in;
   logic [TIME_BITS-1:0]   next_due_ff, next_due_in;
   logic [SUM_W-1:0]       sum_ff, sum_in;
   logic [TAKEN_W-1:0]     taken_ff, taken_in;
   logic [6:0]             last_percent_ff, last_percent_in;
   logic [ADC_BITS-1:0]    last_average_ff, last_average_in;
   logic                   powered_ff, powered_in;

   logic [TIME_BITS-1:0]   now;
   logic [ADC_BITS-1:0]    sample;
   logic [ADC_BITS-1:0]    average;
   logic [TAKEN_W-1:0]     taken_inc;
   logic [6:0]             percent;
   logic                   due;
   logic                   done;
   logic                   start;

   assign now       = item.now_ticks[TIME_BITS-1:0];
   assign sample    = item.adc_sample[ADC_BITS-1:0];
   assign average   = sum_ff[SUM_W-1:SAMPLES_LOG2];
   assign taken_inc = taken_ff + TAKEN_W'(1);
   assign due       = (next_due_ff <= now);

   blsmp_scale #(
      .ADC_BITS (ADC_BITS)
   ) u_scale (
      .average    (average),
      .gain_q16   (cfg.gain_q16),
      .offset_q16 (cfg.offset_q16),
      .percent    (percent)
   );

   always_comb begin
      phase_in        = phase_ff;
      next_due_in     = next_due_ff;
      sum_in          = sum_ff;
      taken_in        = taken_ff;
      last_percent_in = last_percent_ff;
      last_average_in = last_average_ff;
      powered_in      = powered_ff;
      done            = 1'b0;
      start           = 1'b0;
      if (due) begin
         unique case (phase_ff)
            PH_IDLE: begin
               last_average_in = average;
               last_percent_in = percent;
               done            = 1'b1;
               phase_in        = PH_PREPARE;
               next_due_in     = now + TIME_BITS'(cfg.period_ticks);
               sum_in          = '0;
               taken_in        = '0;
            end
            PH_PREPARE: begin
               powered_in = 1'b1;
               phase_in   = PH_START;
            end
            PH_START: begin
               start    = 1'b1;
               phase_in = PH_RESULT;
            end
            PH_RESULT: begin
               if (item.adc_ready) begin
                  sum_in   = sum_ff + SUM_W'(sample);
                  taken_in = taken_inc;
                  // full batch once the count reaches 2^SAMPLES_LOG2
                  if (taken_inc[SAMPLES_LOG2]) begin
                     phase_in   = PH_IDLE;
                     powered_in = 1'b0;
                  end else begin
                     phase_in = PH_START;
                  end
               end
            end
            default: phase_in = phase_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff        <= PH_PREPARE;
         next_due_ff     <= '0;
         sum_ff          <= '0;
         taken_ff        <= '0;
         last_percent_ff <= '0;
         last_average_ff <= '0;
         powered_ff      <= 1'b0;
      end else if (fire) begin
         phase_ff        <= phase_in;
         next_due_ff     <= next_due_in;
         sum_ff          <= sum_in;
         taken_ff        <= taken_in;
         last_percent_ff <= last_percent_in;
         last_average_ff <= last_average_in;
         powered_ff      <= powered_in;
      end
   end

   assign result.measurement_done = done;
   assign result.level_percent    = last_percent_in;
   assign result.average_raw      = 12'(last_average_in);
   assign result.sensor_power     = powered_in;
   assign result.convert_start    = start;

endmodule

@@ hw/rtl/battery_level_sampler_top.sv @@
// Battery level sampler top level: config registers, input register, sequencer, result register.
//
// Usage:
//   req_* carries one scheduler call per word: time, ADC ready flag and sample.
//   rsp_* returns exactly one word per call: done flag, percent, raw average,
//   sensor power and the conversion start pulse. A word moves on a rising edge
//   where valid is high and stall is low.
//   csr_* writes period (index 0), gain (1) and offset (2); csr_ready is
//   always high, unknown indexes are dropped. Write only while the block is
//   empty.
//   A request is registered in the input stage, then in the response stage;
//   one word per cycle is sustained while rsp_stall is low, set by the single
//   registered pass through the sequencer and the 12x17 gain multiplier.
//   Reset (synchronous) empties both stages, restores the register defaults
//   and puts the sequencer in its power-up phase with a due time of zero.
//   A stalled response holds its word; req_stall rises only when the input
//   stage also holds a word that cannot move on.
`include "battery_level_sampler_top_defines.svh"

module battery_level_sampler_top
   import blsmp_pkg::*;
#(
   parameter int SAMPLES_LOG2 = 4,
   parameter int ADC_BITS     = 12,
   parameter int TIME_BITS    = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [31:0] req_now_ticks,
   input  logic        req_adc_ready,
   input  logic [11:0] req_adc_sample,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_measurement_done,
   output logic [6:0]  rsp_level_percent,
   output logic [11:0] rsp_average_raw,
   output logic        rsp_sensor_power,
   output logic        rsp_convert_start,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [26:0] csr_wdata
);

   cfg_type    cfg;
   result_type core_result;

   logic       in_vld_ff, in_vld_in;
   item_type   in_item_ff, in_item_in;
   logic       out_vld_ff, out_vld_in;
   result_type out_rsp_ff, out_rsp_in;

   logic       out_load;
   logic       fire;
   logic       req_accept;

   assign out_load   = !out_vld_ff || !rsp_stall;
   assign fire       = in_vld_ff && out_load;
   assign req_stall  = in_vld_ff && !out_load;
   assign req_accept = req_valid && !req_stall;

   assign in_vld_in  = req_accept || (in_vld_ff && !fire);
   assign in_item_in = req_accept ? item_type'{now_ticks:  req_now_ticks,
                                               adc_ready:  req_adc_ready,
                                               adc_sample: req_adc_sample} : in_item_ff;
   assign out_vld_in = out_load ? in_vld_ff : out_vld_ff;
   assign out_rsp_in = fire ? core_result : out_rsp_ff;

   blsmp_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   blsmp_core #(
      .SAMPLES_LOG2 (SAMPLES_LOG2),
      .ADC_BITS     (ADC_BITS),
      .TIME_BITS    (TIME_BITS)
   ) u_core (
      .clock  (clock),
      .reset  (reset),
      .cfg    (cfg),
      .item   (in_item_ff),
      .fire   (fire),
      .result (core_result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff  <= 1'b0;
         out_vld_ff <= 1'b0;
      end else begin
         in_vld_ff  <= in_vld_in;
         out_vld_ff <= out_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      in_item_ff <= in_item_in;
      out_rsp_ff <= out_rsp_in;
   end

   assign rsp_valid            = out_vld_ff;
   assign rsp_measurement_done = out_rsp_ff.measurement_done;
   assign rsp_level_percent    = out_rsp_ff.level_percent;
   assign rsp_average_raw      = out_rsp_ff.average_raw;
   assign rsp_sensor_power     = out_rsp_ff.sensor_power;
   assign rsp_convert_start    = out_rsp_ff.convert_start;

   `BLS_ASSERT(a_stall_needs_word, req_stall |-> in_vld_ff && out_vld_ff && rsp_stall, "req_stall without a blocked word")
   `BLS_ASSERT(a_pct_range, rsp_valid |-> rsp_level_percent <= 7'(PCT_MAX), "level_percent above 100")
   `BLS_ASSERT(a_done_unpowered, rsp_valid && rsp_measurement_done |-> !rsp_sensor_power && !rsp_convert_start, "report while sensor powered")
   `BLS_ASSERT(a_start_powered, rsp_valid && rsp_convert_start |-> rsp_sensor_power, "conversion start with sensor off")
   `BLS_ASSERT_ALWAYS(a_reset_empties, reset |=> !in_vld_ff && !rsp_valid, "pipeline not empty after reset")

endmodule
